[rtl/core/srrw_pkg.sv]
// shared types and constants for the selective repeat receiver window
// no dependencies; imported by selective_repeat_receiver_window
package srrw_pkg;

    // default geometry of the receive window and the sequence space
    localparam int WINDOW_DEFAULT    = 8;
    localparam int SEQ_SPACE_DEFAULT = 16;

    // fixed field widths
    localparam int SEQ_FIELD_W = 4;
    localparam int LEN_W       = 16;
    localparam int HANDLE_W    = 32;

    // stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // full chunk length after reset
    localparam logic [LEN_W-1:0] FULL_CHUNK_RESET = 16'd1004;

    // result kinds
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    // one reorder slot entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
    } slot_entry_t;

endpackage

[rtl/core/selective_repeat_receiver_window.sv]
// selective repeat receiver window: acknowledges segments, buffers them, delivers in order
// depends on srrw_pkg for field widths, defaults and the slot entry type
//
// Each accepted segment gives an acknowledgement beat first, then zero or more in-order
// delivery beats; m_tlast marks the last beat of a segment. Reorder slots live in a
// WINDOW-entry synchronous memory with a registered read port; received marks are
// flip-flops cleared by reset, so there is no clearing pass and the block is ready right
// after reset. A segment is accepted, then decided and its acknowledgement emitted, then
// each delivered segment, up to WINDOW of them, takes a memory read and then the output
// beat; every step that loads the output register waits while the output side stalls.
// The next segment is taken while the last beat still waits in the output register.
// full_chunk_length is written through cfg_we/cfg_wdata and must only change while idle.
module selective_repeat_receiver_window
    import srrw_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEFAULT,
    parameter int SEQ_SPACE = SEQ_SPACE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: full_chunk_length
    input  logic                  cfg_we,
    input  logic [LEN_W-1:0]      cfg_wdata,
    // input segments
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] sequence_req, [19:4] chunk_length, [51:20] payload_handle, [55:52] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] result_sequence, [19:4] result_length, [51:20] result_handle, [55:52] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] result_kind, [1] final_chunk
    output logic [OUT_USER_W-1:0] m_tuser,
    // last_result
    output logic                  m_tlast
);

    localparam int SEQ_W  = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int OFF_W  = SEQ_W + 1;
    localparam int CMP_W  = OFF_W + 8;
    localparam int WIDE_W = SEQ_W + SEQ_FIELD_W;
    localparam int CNT_W  = $clog2(WINDOW + 1) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_DELIV = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [LEN_W-1:0]       full_len_reg;
    logic [SEQ_W-1:0]       head_reg;
    logic [SLOT_W-1:0]      slot_head_reg;
    logic [SEQ_SPACE-1:0]   marks_reg;
    logic [CNT_W-1:0]       count_reg;

    // latched input segment
    logic [SEQ_FIELD_W-1:0] seq_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [HANDLE_W-1:0]    handle_reg;

    // slot memory and its read register
    slot_entry_t            slot_mem [0:WINDOW-1];
    slot_entry_t            rd_data_reg;

    // output register
    logic                   out_valid_reg;
    logic [SEQ_FIELD_W-1:0] out_seq_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic [HANDLE_W-1:0]    out_handle_reg;
    logic                   out_kind_reg;
    logic                   out_final_reg;
    logic                   out_last_reg;

    logic                   in_beat;
    logic                   out_free;

    // evaluation of the latched segment
    logic [WIDE_W-1:0]      seq_wide;
    logic                   seq_in_space;
    logic [SEQ_W-1:0]       seq_idx;
    logic [OFF_W-1:0]       off_sum;
    logic [OFF_W-1:0]       offset;
    logic                   in_window;
    logic                   do_store;
    logic                   at_head;
    logic [SLOT_W:0]        slot_sum;
    logic [SLOT_W-1:0]      wr_slot;

    // delivery step
    logic [SEQ_W-1:0]       head_inc;
    logic [SLOT_W-1:0]      slot_head_inc;
    logic                   dlv_final;
    logic                   dlv_last;
    logic [WIDE_W-1:0]      head_wide;

    logic                   ack_load;
    logic                   dlv_load;
    logic                   mem_re;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // sequence range check and window offset
    always_comb
    begin
        seq_wide     = {{SEQ_W{1'b0}}, seq_reg};
        seq_in_space = seq_wide < WIDE_W'(SEQ_SPACE);
        seq_idx      = seq_wide[SEQ_W-1:0];
        off_sum      = {1'b0, seq_idx} + OFF_W'(SEQ_SPACE) - {1'b0, head_reg};
        if (off_sum >= OFF_W'(SEQ_SPACE))
        begin
            offset = off_sum - OFF_W'(SEQ_SPACE);
        end
        else
        begin
            offset = off_sum;
        end
        in_window = CMP_W'(offset) < CMP_W'(WINDOW);
        do_store  = seq_in_space && in_window && !marks_reg[seq_idx];
        at_head   = (offset == '0);
        slot_sum  = {1'b0, slot_head_reg} + (SLOT_W + 1)'(offset);
        if (slot_sum >= (SLOT_W + 1)'(WINDOW))
        begin
            wr_slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW));
        end
        else
        begin
            wr_slot = slot_sum[SLOT_W-1:0];
        end
    end

    // head advance and end-of-run detection for a delivery
    always_comb
    begin
        if (head_reg == SEQ_W'(SEQ_SPACE - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg + 1'b1;
        end
        if (slot_head_reg == SLOT_W'(WINDOW - 1))
        begin
            slot_head_inc = '0;
        end
        else
        begin
            slot_head_inc = slot_head_reg + 1'b1;
        end
        dlv_final = rd_data_reg.length < full_len_reg;
        dlv_last  = dlv_final || (count_reg + 1'b1 == CNT_W'(WINDOW)) || !marks_reg[head_inc];
        head_wide = {{SEQ_FIELD_W{1'b0}}, head_reg};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        ack_load   = 1'b0;
        dlv_load   = 1'b0;
        mem_re     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    ack_load = 1'b1;
                    if (do_store && at_head)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_DELIV;
            end
            ST_DELIV:
            begin
                if (out_free)
                begin
                    dlv_load = 1'b1;
                    if (dlv_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            full_len_reg  <= FULL_CHUNK_RESET;
            head_reg      <= '0;
            slot_head_reg <= '0;
            marks_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                full_len_reg <= cfg_wdata;
            end
            // mark set on store, clear on delivery
            if (ack_load && do_store)
            begin
                marks_reg[seq_idx] <= 1'b1;
                count_reg          <= '0;
            end
            if (dlv_load)
            begin
                marks_reg[head_reg] <= 1'b0;
                head_reg            <= head_inc;
                slot_head_reg       <= slot_head_inc;
                count_reg           <= count_reg + 1'b1;
            end
            if (ack_load || dlv_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input segment capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            seq_reg    <= s_tdata[SEQ_FIELD_W-1:0];
            len_reg    <= s_tdata[SEQ_FIELD_W +: LEN_W];
            handle_reg <= s_tdata[SEQ_FIELD_W + LEN_W +: HANDLE_W];
        end
    end

    // reorder slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ack_load && do_store)
        begin
            slot_mem[wr_slot] <= '{handle: handle_reg, length: len_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[slot_head_reg];
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (ack_load)
        begin
            out_kind_reg   <= KIND_ACK;
            out_seq_reg    <= seq_reg;
            out_len_reg    <= '0;
            out_handle_reg <= '0;
            out_final_reg  <= 1'b0;
            out_last_reg   <= !(do_store && at_head);
        end
        else if (dlv_load)
        begin
            out_kind_reg   <= KIND_DELIVER;
            out_seq_reg    <= head_wide[SEQ_FIELD_W-1:0];
            out_len_reg    <= rd_data_reg.length;
            out_handle_reg <= rd_data_reg.handle;
            out_final_reg  <= dlv_final;
            out_last_reg   <= dlv_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SEQ_FIELD_W - LEN_W - HANDLE_W){1'b0}},
                       out_handle_reg, out_len_reg, out_seq_reg};
    assign m_tuser  = {out_final_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

endmodule
